[sv/sqe_pkg.sv]
package sqe_pkg;

  localparam int MAX_SAMPLES_DEF  = 256;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int PROB_W           = 17;
  localparam int FRAC_W           = 16;
  localparam logic [PROB_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] sample_value;
    logic [16:0] prob_fraction;
  } in_req_t;

  typedef struct packed {
    logic [31:0] quantile_value;
    logic        status;
  } out_req_t;

endpackage

[sv/sqe_interp.sv]
// interpolation term: |diff|*frac/65536 rounded, split in two registered multiplies
module sqe_interp #(
  parameter int SAMPLE_WIDTH = sqe_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    start,
  input  logic [SAMPLE_WIDTH-1:0] base,
  input  logic [SAMPLE_WIDTH-1:0] upper,
  input  logic [15:0]             frac,
  output logic [SAMPLE_WIDTH-1:0] result
);
  localparam int DW = SAMPLE_WIDTH + 1;

  logic signed [DW-1:0] diff;
  logic [DW-1:0] mag;
  logic [DW-1:0] mag_r;
  logic [15:0] frac_r;
  logic neg_r;
  logic [SAMPLE_WIDTH-1:0] base_r;
  logic [DW+15:0] hi_prod_r;
  logic [31:0] lo_prod_r;
  logic [DW-1:0] term;

  assign diff = $signed({upper[SAMPLE_WIDTH-1], upper}) - $signed({base[SAMPLE_WIDTH-1], base});
  assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r  <= mag;
      frac_r <= frac;
      neg_r  <= diff[DW-1];
      base_r <= base;
    end
    hi_prod_r <= (DW+16)'(mag_r >> 16) * (DW+16)'(frac_r);
    lo_prod_r <= 32'(mag_r[15:0]) * 32'(frac_r);
  end

  assign term = DW'(hi_prod_r) + DW'((lo_prod_r + 32'h8000) >> 16);
  assign result = neg_r ? SAMPLE_WIDTH'(base_r - term[SAMPLE_WIDTH-1:0])
                        : SAMPLE_WIDTH'(base_r + term[SAMPLE_WIDTH-1:0]);
endmodule

[sv/sample_quantile_engine_top.sv]
// load: ordered insert walks down the set, shifting larger entries up; ignored when the set is full
// query: interpolates between the samples around (n-1)*p; 0 with status 1 on an empty set
// clear: empties the set; a query result sits in an output register, new requests wait until taken
// one request at a time, set by the single memory port of the sample store
// reset clears the sample count and control state; sample memory is not cleared
module sample_quantile_engine_top #(
  parameter int MAX_SAMPLES  = sqe_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_WIDTH = sqe_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sqe_pkg::in_req_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output sqe_pkg::out_req_t out_data
);
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int PW = CW + 17;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_RDLO  = 3'd3;
  localparam logic [2:0] S_RDHI  = 3'd4;
  localparam logic [2:0] S_INTP  = 3'd5;
  localparam logic [2:0] S_INTP2 = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] pos_r;
  logic [SAMPLE_WIDTH-1:0] new_r;
  logic [16:0] prob_r;
  logic [PW-1:0] position_r;
  logic [SAMPLE_WIDTH-1:0] mem [MAX_SAMPLES];
  logic [SAMPLE_WIDTH-1:0] rd_r;
  logic [SAMPLE_WIDTH-1:0] lo_val_r;
  logic [AW-1:0] rd_addr;
  logic rd_pending_r;
  logic exact_r;
  logic interp_start;
  logic [SAMPLE_WIDTH-1:0] interp_res;
  logic out_valid_r;
  sqe_pkg::out_req_t out_data_r;
  logic accept;
  logic [CW-1:0] lo_idx;
  logic [CW-1:0] nm1;
  logic ins_done;

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign nm1       = count_r - CW'(1);
  assign lo_idx    = CW'(position_r >> 16);
  assign ins_done  = (pos_r == '0) || (!rd_pending_r && !($signed(rd_r) > $signed(new_r)));

  // insert walk: read entry pos-1, compare/shift it in the next cycle; query reads samples lo and lo+1
  always_comb begin
    rd_addr = AW'(pos_r - CW'(1));
    unique case (state_r)
      S_RDLO:  rd_addr = AW'(lo_idx);
      S_RDHI:  rd_addr = AW'(lo_idx + CW'(1));
      default: rd_addr = AW'(pos_r - CW'(1));
    endcase
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[rd_addr];
  end

  // upper sample is in rd_r only during the first interpolation cycle
  assign interp_start = (state_r == S_INTP) && rd_pending_r;

  sqe_interp #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_interp (
    .clk    (clk),
    .start  (interp_start),
    .base   (lo_val_r),
    .upper  (rd_r),
    .frac   (position_r[15:0]),
    .result (interp_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.action)
            sqe_pkg::ACT_LOAD:
              state_nxt = (count_r >= CW'(MAX_SAMPLES)) ? S_IDLE : S_INS;
            sqe_pkg::ACT_QUERY: state_nxt = (count_r == '0) ? S_IDLE : S_MUL;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS:   state_nxt = ins_done ? S_IDLE : S_INS;
      S_MUL:   state_nxt = S_RDLO;
      S_RDLO:  state_nxt = S_RDHI;
      S_RDHI:  state_nxt = S_INTP;
      S_INTP:  state_nxt = rd_pending_r ? S_INTP : (exact_r ? S_DONE : S_INTP2);
      S_INTP2: state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      rd_pending_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            new_r  <= SAMPLE_WIDTH'(in_data.sample_value);
            pos_r  <= count_r;
            prob_r <= (in_data.prob_fraction > sqe_pkg::ONE_Q16) ? sqe_pkg::ONE_Q16
                                                                  : in_data.prob_fraction;
            rd_pending_r <= 1'b1;
            if (in_data.action == sqe_pkg::ACT_CLEAR) count_r <= '0;
            if (in_data.action == sqe_pkg::ACT_QUERY && count_r == '0) begin
              out_valid_r <= 1'b1;
              out_data_r.quantile_value <= '0;
              out_data_r.status <= 1'b1;
            end
          end
        end
        S_INS: begin
          if (pos_r == '0) begin
            mem[0] <= new_r;
            count_r <= count_r + CW'(1);
          end else if (rd_pending_r) begin
            rd_pending_r <= 1'b0;
          end else if ($signed(rd_r) > $signed(new_r)) begin
            mem[AW'(pos_r)] <= rd_r;
            pos_r <= pos_r - CW'(1);
            rd_pending_r <= 1'b1;
          end else begin
            mem[AW'(pos_r)] <= new_r;
            count_r <= count_r + CW'(1);
          end
        end
        S_MUL: begin
          position_r <= PW'(nm1) * PW'(prob_r);
        end
        S_RDLO: begin
          rd_pending_r <= 1'b1;
        end
        S_RDHI: begin
          lo_val_r <= rd_r;
          exact_r  <= (position_r[15:0] == '0) || (lo_idx + CW'(1) >= count_r);
        end
        S_INTP: begin
          rd_pending_r <= 1'b0;
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          out_data_r.quantile_value <= 32'($signed(exact_r ? lo_val_r : interp_res));
          out_data_r.status <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule
